// ===== design/sct_pkg.sv =====
// Shared constants and channel types for the Taylor-series sine/cosine block.
`timescale 1ns / 1ps

package sct_pkg;

   // Field widths
   localparam int ANGLE_W = 32;
   localparam int Q30_W   = 32;
   localparam int TERMS_W = 7;
   localparam int THR_W   = 21;

   // Defaults
   localparam int              MAX_TERMS_DEF = 24;
   localparam logic [THR_W-1:0] THR_RESET    = 21'd72;

   // Q7.56 constants
   localparam logic [63:0] ONE_Q56    = 64'h0100_0000_0000_0000;
   localparam logic [63:0] TWO_PI_Q56 = 64'd452751216129849975;
   localparam logic [63:0] Q56_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] Q56_MIN    = 64'h8000_0000_0000_0000;

   // Request to the shared multiplier
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   // Response from the shared multiplier
   typedef struct packed {
      logic        done;
      logic [63:0] p;
   } mul_rsp_type;

endpackage

// ===== design/sct_mul.sv =====
// Iterative Q7.56 multiplier: one 32x32 multiplier over four partial products.
`timescale 1ns / 1ps

module sct_mul
   import sct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_FIN} state_type;

   localparam logic [2:0]   LAST_STEP = 3'd4;
   localparam logic [127:0] ROUND_Q56 = 128'd1 << 55;

   state_type    state_ff;
   logic [63:0]  mag_a_ff, mag_b_ff;
   logic         neg_ff;
   logic [127:0] acc_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   pp_sel_ff;
   logic         pp_valid_ff;
   logic [2:0]   step_ff;
   logic [63:0]  prod_ff;
   logic         done_ff;

   logic [63:0]  mag_a, mag_b;
   logic [31:0]  half_a, half_b;
   logic [127:0] pp_wide, acc_sum;
   logic [71:0]  rnd_mag;
   logic [63:0]  sat_mag;

   // operand magnitudes
   assign mag_a = mul_req.a[63] ? (64'd0 - mul_req.a) : mul_req.a;
   assign mag_b = mul_req.b[63] ? (64'd0 - mul_req.b) : mul_req.b;

   // halves picked by the step count
   assign half_a = step_ff[0] ? mag_a_ff[63:32] : mag_a_ff[31:0];
   assign half_b = step_ff[1] ? mag_b_ff[63:32] : mag_b_ff[31:0];

   // align the registered partial product
   always_comb begin
      case (pp_sel_ff)
         2'd0:    pp_wide = {64'd0, pp_ff};
         2'd3:    pp_wide = {pp_ff, 64'd0};
         default: pp_wide = {32'd0, pp_ff, 32'd0};
      endcase
   end

   assign acc_sum = acc_ff + pp_wide;

   // accumulator started at one half LSB, so only truncation and clamp remain
   assign rnd_mag = acc_ff[127:56];
   assign sat_mag = (rnd_mag[71:63] != 9'd0) ? Q56_MAX : rnd_mag[63:0];

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         done_ff     <= 1'b0;
         pp_valid_ff <= 1'b0;
         step_ff     <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (mul_req.start) begin
                  mag_a_ff    <= mag_a;
                  mag_b_ff    <= mag_b;
                  neg_ff      <= mul_req.a[63] ^ mul_req.b[63];
                  acc_ff      <= ROUND_Q56;
                  step_ff     <= 3'd0;
                  pp_valid_ff <= 1'b0;
                  state_ff    <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (pp_valid_ff) begin
                  acc_ff <= acc_sum;
               end
               if (step_ff == LAST_STEP) begin
                  pp_valid_ff <= 1'b0;
                  state_ff    <= ST_FIN;
               end else begin
                  pp_ff       <= 64'(half_a) * 64'(half_b);
                  pp_sel_ff   <= step_ff[1:0];
                  pp_valid_ff <= 1'b1;
                  step_ff     <= step_ff + 3'd1;
               end
            end
            ST_FIN: begin
               prod_ff  <= neg_ff ? (64'd0 - sat_mag) : sat_mag;
               done_ff  <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.p    = prod_ff;

endmodule

// ===== design/sct_seq.sv =====
// Sequencer: angle reduction, both Taylor series and Q2.30 conversion.
`timescale 1ns / 1ps

module sct_seq
   import sct_pkg::*;
#(
   parameter int MAX_TERMS = MAX_TERMS_DEF
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [ANGLE_W-1:0] angle,
   input  logic [THR_W-1:0]   threshold,
   output logic               rsp_valid,
   output logic [Q30_W-1:0]   rsp_sine,
   output logic [Q30_W-1:0]   rsp_cosine,
   output logic [TERMS_W-1:0] rsp_terms_used,
   output logic               rsp_hit_limit
);

   localparam int RECIP_COUNT = 2 * MAX_TERMS + 2;
   localparam int K_W         = $clog2(RECIP_COUNT);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RED, ST_SQ_GO, ST_SQ_WAIT, ST_ADD, ST_M1_GO, ST_M1_WAIT,
      ST_M2_GO, ST_M2_WAIT, ST_CHK, ST_CVT_MAG, ST_CVT_RND, ST_OUT
   } state_type;

   state_type          state_ff;
   logic [63:0]        mag_ff;
   logic               ang_neg_ff;
   logic [63:0]        nx2_ff;
   logic [63:0]        term_ff;
   logic [63:0]        sum_ff;
   logic [K_W-1:0]     k_ff;
   logic [TERMS_W-1:0] cnt_ff;
   logic               cos_sel_ff;
   logic               lim_ff;
   logic [TERMS_W-1:0] ns_ff;
   logic               ls_ff;
   logic [63:0]        cvt_mag_ff;
   logic               cvt_neg_ff;
   logic               rsp_valid_ff;
   logic [Q30_W-1:0]   rsp_sine_ff, rsp_cosine_ff;
   logic [TERMS_W-1:0] rsp_terms_ff;
   logic               rsp_hit_ff;

   logic [63:0]        recip_tab [RECIP_COUNT];
   logic [63:0]        wide, wide_mag, term_mag, sum_add, sum_sat, cvt_rnd;
   logic               sum_ovf;
   logic [37:0]        cvt_r;
   logic [Q30_W-1:0]   q30;
   mul_req_type        mul_req;
   mul_rsp_type        mul_rsp;

   // reciprocal table 1/(k*(k+1)) in Q7.56, worked out at elaboration
   for (genvar g = 0; g < RECIP_COUNT; g++) begin : g_recip
      if (g == 0) begin : g_zero
         assign recip_tab[g] = 64'd0;
      end else begin : g_entry
         localparam logic [63:0] DEN   = 64'(g) * 64'(g + 1);
         localparam logic [63:0] RECIP = (ONE_Q56 + DEN / 2) / DEN;
         assign recip_tab[g] = RECIP;
      end
   end

   // widened angle and its magnitude
   assign wide     = {{2{angle[ANGLE_W-1]}}, angle, 30'd0};
   assign wide_mag = angle[ANGLE_W-1] ? (64'd0 - wide) : wide;

   assign term_mag = term_ff[63] ? (64'd0 - term_ff) : term_ff;

   // saturating accumulate
   assign sum_add = sum_ff + term_ff;
   assign sum_ovf = (sum_ff[63] == term_ff[63]) && (sum_add[63] != sum_ff[63]);
   assign sum_sat = sum_ovf ? (sum_ff[63] ? Q56_MIN : Q56_MAX) : sum_add;

   // Q7.56 to Q2.30: round on magnitude, clamp, restore sign
   assign cvt_rnd = cvt_mag_ff + (64'd1 << 25);
   assign cvt_r   = cvt_rnd[63:26];
   always_comb begin
      if (cvt_neg_ff) begin
         q30 = (cvt_r > 38'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - cvt_r[31:0]);
      end else begin
         q30 = (cvt_r > 38'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : cvt_r[31:0];
      end
   end

   // multiplier operands by step
   always_comb begin
      mul_req.start = 1'b0;
      mul_req.a     = term_ff;
      mul_req.b     = term_ff;
      case (state_ff)
         ST_SQ_GO: mul_req.start = 1'b1;
         ST_M1_GO: begin
            mul_req.start = 1'b1;
            mul_req.b     = recip_tab[k_ff];
         end
         ST_M2_GO: begin
            mul_req.start = 1'b1;
            mul_req.b     = nx2_ff;
         end
         default: mul_req.start = 1'b0;
      endcase
   end

   sct_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         cos_sel_ff   <= 1'b0;
         lim_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  mag_ff     <= wide_mag;
                  ang_neg_ff <= angle[ANGLE_W-1];
                  cos_sel_ff <= 1'b0;
                  k_ff       <= K_W'(2);
                  cnt_ff     <= '0;
                  sum_ff     <= 64'd0;
                  lim_ff     <= 1'b0;
                  state_ff   <= ST_RED;
               end
            end
            // subtract two pi until below it
            ST_RED: begin
               if (mag_ff >= TWO_PI_Q56) begin
                  mag_ff <= mag_ff - TWO_PI_Q56;
               end else begin
                  term_ff  <= ang_neg_ff ? (64'd0 - mag_ff) : mag_ff;
                  state_ff <= ST_SQ_GO;
               end
            end
            ST_SQ_GO: state_ff <= ST_SQ_WAIT;
            ST_SQ_WAIT: begin
               if (mul_rsp.done) begin
                  nx2_ff   <= 64'd0 - mul_rsp.p;
                  state_ff <= ST_ADD;
               end
            end
            ST_ADD: begin
               sum_ff   <= sum_sat;
               cnt_ff   <= cnt_ff + TERMS_W'(1);
               state_ff <= ST_M1_GO;
            end
            ST_M1_GO: state_ff <= ST_M1_WAIT;
            ST_M1_WAIT: begin
               if (mul_rsp.done) begin
                  term_ff  <= mul_rsp.p;
                  state_ff <= ST_M2_GO;
               end
            end
            ST_M2_GO: state_ff <= ST_M2_WAIT;
            ST_M2_WAIT: begin
               if (mul_rsp.done) begin
                  term_ff  <= mul_rsp.p;
                  k_ff     <= k_ff + K_W'(2);
                  state_ff <= ST_CHK;
               end
            end
            // stop test on the next term
            ST_CHK: begin
               if (term_mag <= 64'(threshold)) begin
                  lim_ff   <= 1'b0;
                  state_ff <= ST_CVT_MAG;
               end else if (cnt_ff >= TERMS_W'(MAX_TERMS)) begin
                  lim_ff   <= 1'b1;
                  state_ff <= ST_CVT_MAG;
               end else begin
                  state_ff <= ST_ADD;
               end
            end
            ST_CVT_MAG: begin
               cvt_mag_ff <= sum_ff[63] ? (64'd0 - sum_ff) : sum_ff;
               cvt_neg_ff <= sum_ff[63];
               state_ff   <= ST_CVT_RND;
            end
            ST_CVT_RND: begin
               if (!cos_sel_ff) begin
                  rsp_sine_ff <= q30;
                  ns_ff       <= cnt_ff;
                  ls_ff       <= lim_ff;
                  cos_sel_ff  <= 1'b1;
                  term_ff     <= ONE_Q56;
                  k_ff        <= K_W'(1);
                  cnt_ff      <= '0;
                  sum_ff      <= 64'd0;
                  state_ff    <= ST_ADD;
               end else begin
                  rsp_cosine_ff <= q30;
                  state_ff      <= ST_OUT;
               end
            end
            ST_OUT: begin
               rsp_terms_ff <= (ns_ff > cnt_ff) ? ns_ff : cnt_ff;
               rsp_hit_ff   <= ls_ff | lim_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sine       = rsp_sine_ff;
   assign rsp_cosine     = rsp_cosine_ff;
   assign rsp_terms_used = rsp_terms_ff;
   assign rsp_hit_limit  = rsp_hit_ff;

   // multiplier answers only while a step waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == ST_SQ_WAIT || state_ff == ST_M1_WAIT ||
                        state_ff == ST_M2_WAIT))
      else $error("multiplier result outside a wait step");

   // reduction is complete before squaring
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_GO) |-> (mag_ff < TWO_PI_Q56))
      else $error("angle not reduced below two pi");

   // term count stays within the limit
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= TERMS_W'(MAX_TERMS))
      else $error("term count above limit");

   // result strobe only once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE && cos_sel_ff))
      else $error("result strobe while busy");

endmodule

// ===== design/sine_cosine_taylor_series_top.sv =====
// Top level of the Taylor-series sine/cosine block: threshold register and sequencer.
`timescale 1ns / 1ps
//
// Usage:
//  - Input: drive req_angle (signed Q5.26 radians) and raise start; the
//    transfer happens at the clock edge where start is high and busy is low.
//    busy stays high until the result strobe.
//  - Output: rsp_sine / rsp_cosine (signed Q2.30, saturated), rsp_terms_used
//    and rsp_hit_limit are valid for exactly one cycle while rsp_valid is high.
//    The receiver cannot stall; it must take the result in that cycle.
//  - Config: csr_wr_en with csr_wr_data writes the 21-bit stop threshold
//    (units of 2^-56); write only while busy is low.
//  - Sequence: reduction takes q = 0..5 two-pi subtractions, and each series
//    sums 1..MAX_TERMS terms. All products go through the single shared
//    32x32 multiplier, two Q7.56 products per term.
//  - Overlap: no new angle until the last is done; busy is already low in the
//    result strobe cycle, so a start held then is taken at the edge that ends it.
//  - Reset (synchronous, active high): sequencer to idle, no result pending,
//    threshold back to 72.
//
module sine_cosine_taylor_series_top
   import sct_pkg::*;
#(
   parameter int MAX_TERMS = MAX_TERMS_DEF
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [ANGLE_W-1:0] req_angle,
   output logic               rsp_valid,
   output logic [Q30_W-1:0]   rsp_sine,
   output logic [Q30_W-1:0]   rsp_cosine,
   output logic [TERMS_W-1:0] rsp_terms_used,
   output logic               rsp_hit_limit,
   input  logic               csr_wr_en,
   input  logic [THR_W-1:0]   csr_wr_data
);

   logic [THR_W-1:0] threshold_ff;

   // stop threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   sct_seq #(
      .MAX_TERMS (MAX_TERMS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .angle          (req_angle),
      .threshold      (threshold_ff),
      .rsp_valid      (rsp_valid),
      .rsp_sine       (rsp_sine),
      .rsp_cosine     (rsp_cosine),
      .rsp_terms_used (rsp_terms_used),
      .rsp_hit_limit  (rsp_hit_limit)
   );

endmodule

// ===== tb/sv/sine_cosine_taylor_series_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Taylor-series sine/cosine block.
module sine_cosine_taylor_series_top_tb;
   import sct_pkg::*;

   localparam int TWO_PI_Q26   = 421657428;  // 2*pi in Q5.26, rounded down
   localparam int PI_Q26       = 210828714;
   localparam int RECIP_N      = 2 * MAX_TERMS_DEF + 2;
   localparam int IDLE_LIMIT   = 5000;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 250;
   localparam int DRAIN_CYCLES = 1000;
   localparam int ROWS         = 22;

   typedef struct packed {
      logic [Q30_W-1:0]   sine;
      logic [Q30_W-1:0]   cosine;
      logic [TERMS_W-1:0] terms;
      logic               hit;
   } trig_result_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [THR_W-1:0]   thr;
      logic               known;
      trig_result_type    res;
   } angle_case_type;

   localparam trig_result_type NO_RESULT = '0;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [ANGLE_W-1:0] req_angle = '0;
   logic               rsp_valid;
   logic [Q30_W-1:0]   rsp_sine;
   logic [Q30_W-1:0]   rsp_cosine;
   logic [TERMS_W-1:0] rsp_terms_used;
   logic               rsp_hit_limit;
   logic               csr_wr_en = 1'b0;
   logic [THR_W-1:0]   csr_wr_data = '0;

   trig_result_type    trig_expected[$];
   logic [THR_W-1:0]   stop_thr = THR_RESET;
   angle_case_type     angle_cases [ROWS];
   int                 fail_count = 0;
   int                 idle_cycles = 0;

   sine_cosine_taylor_series_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_angle      (req_angle),
      .rsp_valid      (rsp_valid),
      .rsp_sine       (rsp_sine),
      .rsp_cosine     (rsp_cosine),
      .rsp_terms_used (rsp_terms_used),
      .rsp_hit_limit  (rsp_hit_limit),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------- Q7.56 arithmetic ----------------

   function automatic logic [63:0] q56_abs(input logic signed [63:0] v);
      return v[63] ? -v : v;
   endfunction

   // clamp magnitude to the positive bound, then attach the sign
   function automatic logic signed [63:0] q56_sign(input logic [63:0] mag, input logic neg);
      if (mag > Q56_MAX) mag = Q56_MAX;
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   // full product, rounded to nearest on the magnitude, saturated
   function automatic logic signed [63:0] q56_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic [127:0] p;
      logic [63:0]  m;
      p = {64'd0, q56_abs(a)} * {64'd0, q56_abs(b)} + (128'd1 << 55);
      if (|p[127:119]) m = Q56_MAX;
      else m = p[119:56];
      return q56_sign(m, a[63] ^ b[63]);
   endfunction

   function automatic logic signed [63:0] q56_add_sat(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q56_MIN : Q56_MAX;
      return s[63:0];
   endfunction

   function automatic logic [Q30_W-1:0] q56_to_q30(input logic signed [63:0] s);
      logic [63:0] r;
      r = (q56_abs(s) + 64'd33554432) >> 26;
      if (s[63]) begin
         if (r > 64'h8000_0000) r = 64'h8000_0000;
         r = 64'd0 - r;
      end else if (r > 64'h7FFF_FFFF) begin
         r = 64'h7FFF_FFFF;
      end
      return r[31:0];
   endfunction

   // 1/(k*(k+1)) in Q7.56, rounded to nearest
   function automatic logic signed [63:0] q56_recip(input int k);
      logic [63:0] d;
      if (k <= 0 || k >= RECIP_N) return '0;
      d = 64'(k) * 64'(k + 1);
      return (ONE_Q56 + d / 2) / d;
   endfunction

   // one Taylor series: term_{n+1} = term_n * recip(k) * (-x^2), k steps by 2
   function automatic logic signed [63:0] taylor_sum(input logic signed [63:0] first,
                                                     input logic signed [63:0] neg_x2,
                                                     input int first_k,
                                                     input logic [THR_W-1:0] thr,
                                                     output int used,
                                                     output logic limited);
      logic signed [63:0] sum;
      logic signed [63:0] term;
      int                 k;
      bit                 done;
      sum     = '0;
      term    = first;
      k       = first_k;
      used    = 0;
      limited = 1'b0;
      done    = 1'b0;
      while (!done) begin
         sum  = q56_add_sat(sum, term);
         used = used + 1;
         term = q56_mul(q56_mul(term, q56_recip(k)), neg_x2);
         k    = k + 2;
         if (q56_abs(term) <= {43'd0, thr}) begin
            done = 1'b1;
         end else if (used >= MAX_TERMS_DEF) begin
            limited = 1'b1;
            done    = 1'b1;
         end
      end
      return sum;
   endfunction

   // range reduction by 2*pi, then both series
   function automatic trig_result_type predict_trig(input logic [ANGLE_W-1:0] a,
                                                    input logic [THR_W-1:0] thr);
      trig_result_type    r;
      logic signed [63:0] wide;
      logic [63:0]        mag;
      logic [63:0]        q;
      logic signed [63:0] x;
      logic signed [63:0] neg_x2;
      logic signed [63:0] s;
      logic signed [63:0] c;
      int                 ns;
      int                 nc;
      logic               ls;
      logic               lc;
      wide   = {{2{a[31]}}, a, 30'd0};
      mag    = q56_abs(wide);
      q      = mag / TWO_PI_Q56;
      x      = q56_sign(mag - q * TWO_PI_Q56, wide[63]);
      neg_x2 = -q56_mul(x, x);
      s      = taylor_sum(x, neg_x2, 2, thr, ns, ls);
      c      = taylor_sum(ONE_Q56, neg_x2, 1, thr, nc, lc);
      r.sine   = q56_to_q30(s);
      r.cosine = q56_to_q30(c);
      r.terms  = TERMS_W'(ns > nc ? ns : nc);
      r.hit    = ls | lc;
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------

   // mix of full-range, small, near-multiple-of-pi and extreme angles
   function automatic logic [ANGLE_W-1:0] random_angle();
      logic [31:0] mag;
      logic        neg;
      neg = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5:       mag = $urandom_range(0, 32'h0800_0000);
         6, 7:       mag = $urandom_range(0, 5) * TWO_PI_Q26 + $urandom_range(0, 64) - 32;
         8:          mag = $urandom_range(0, 10) * PI_Q26 + $urandom_range(0, 16);
         default: begin
            case ($urandom_range(0, 3))
               0:       return 32'h0000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h8000_0000;
               default: mag = 32'd1;
            endcase
         end
      endcase
      return neg ? -mag : mag;
   endfunction

   // offer one angle and hold start until the transfer
   task automatic send_angle(input logic [ANGLE_W-1:0] a, input logic known,
                             input trig_result_type fixed);
      req_angle <= a;
      start     <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      trig_expected.push_back(known ? fixed : predict_trig(a, stop_thr));
   endtask

   task automatic sender_gap(input bit allow);
      if (allow && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // stop offering and wait for every outstanding result
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (trig_expected.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] v);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      stop_thr     = v;
   endtask

   // ---------------- main sequence ----------------
   initial begin
      logic [THR_W-1:0] thr_new;
      // angle, threshold, known, sine, cosine, terms, hit_limit
      angle_cases = '{
         {32'h0000_0000, 21'd72, 1'b1, 32'h0000_0000, 32'h4000_0000, 7'd1, 1'b0},
         {32'h0000_0001, 21'd72, 1'b1, 32'h0000_0010, 32'h4000_0000, 7'd1, 1'b0},
         {32'hFFFF_FFFF, 21'd72, 1'b1, 32'hFFFF_FFF0, 32'h4000_0000, 7'd1, 1'b0},
         {32'h7FFF_FFFF, 21'd72, 1'b0, NO_RESULT},
         {32'h8000_0000, 21'd72, 1'b0, NO_RESULT},
         {32'h0648_7ED5, 21'd72, 1'b0, NO_RESULT},      // pi/2
         {32'h0C90_FDAA, 21'd72, 1'b0, NO_RESULT},      // pi
         {32'hF36F_0256, 21'd72, 1'b0, NO_RESULT},      // -pi
         {32'h1921_FB54, 21'd72, 1'b0, NO_RESULT},      // just below 2*pi
         {32'h1921_FB55, 21'd72, 1'b0, NO_RESULT},      // just above 2*pi
         {32'hE6DE_04AB, 21'd72, 1'b0, NO_RESULT},      // just below -2*pi
         {32'd2108287141, 21'd72, 1'b0, NO_RESULT},     // around 10*pi
         {32'd2108287142, 21'd72, 1'b0, NO_RESULT},
         {32'h1800_0000, 21'd72, 1'b0, NO_RESULT},      // 6.0 rad, long series
         {32'h0000_0000, 21'd0, 1'b1, 32'h0000_0000, 32'h4000_0000, 7'd1, 1'b0},
         {32'h1800_0000, 21'd0, 1'b0, NO_RESULT},
         {32'h7FFF_FFFF, 21'd0, 1'b0, NO_RESULT},
         {32'h8000_0000, 21'd0, 1'b0, NO_RESULT},
         {32'h0000_0000, 21'd1048576, 1'b1, 32'h0000_0000, 32'h4000_0000, 7'd1, 1'b0},
         {32'h0000_0001, 21'd1048576, 1'b1, 32'h0000_0010, 32'h4000_0000, 7'd1, 1'b0},
         {32'h1800_0000, 21'd1048576, 1'b0, NO_RESULT},
         {32'h0C90_FDAA, 21'd1, 1'b0, NO_RESULT}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < ROWS; i++) begin
         if (angle_cases[i].thr != stop_thr) write_threshold(angle_cases[i].thr);
         send_angle(angle_cases[i].angle, angle_cases[i].known, angle_cases[i].res);
         sender_gap(1'b1);
      end

      // random phases, one threshold each; the last phase runs without gaps
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       thr_new = THR_RESET;
            1:       thr_new = '0;
            2:       thr_new = 21'd1048576;
            3:       thr_new = THR_W'($urandom_range(0, 1048576));
            4:       thr_new = THR_W'($urandom_range(0, 1023));
            5:       thr_new = 21'd1;
            default: thr_new = THR_W'($urandom_range(0, 200));
         endcase
         write_threshold(thr_new);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_angle(random_angle(), 1'b0, NO_RESULT);
            sender_gap(p != PHASES - 1);
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // ---------------- result checking ----------------
   always @(posedge clock) begin : result_check
      trig_result_type want;
      if (!reset && rsp_valid) begin
         if (trig_expected.size() == 0) begin
            $error("result transfer with no angle outstanding");
            fail_count++;
         end else begin
            want = trig_expected.pop_front();
            if (rsp_sine !== want.sine) begin
               $error("sine: expected %h, actual %h", want.sine, rsp_sine);
               fail_count++;
            end
            if (rsp_cosine !== want.cosine) begin
               $error("cosine: expected %h, actual %h", want.cosine, rsp_cosine);
               fail_count++;
            end
            if (rsp_terms_used !== want.terms) begin
               $error("terms_used: expected %0d, actual %0d", want.terms, rsp_terms_used);
               fail_count++;
            end
            if (rsp_hit_limit !== want.hit) begin
               $error("hit_limit: expected %b, actual %b", want.hit, rsp_hit_limit);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
